// ===== rtl/dps_pkg.sv =====
// shared types and constants of the delta parent selector
// no dependencies

package dps_pkg;

   localparam int MAX_WINDOW_DEFAULT    = 64;
   localparam int MAX_POSITIONS_DEFAULT = 512;

   localparam logic [8:0] ROW_WIDTH_RESET   = 9'd20;
   localparam logic [6:0] WINDOW_SIZE_RESET = 7'd64;

   typedef enum logic [2:0] {
      ORIGIN_ZERO   = 3'd0,
      ORIGIN_LEFT   = 3'd1,
      ORIGIN_UP     = 3'd2,
      ORIGIN_PREV   = 3'd3,
      ORIGIN_WINDOW = 3'd4
   } origin_type;

   typedef enum logic {
      REG_ROW_WIDTH   = 1'b0,
      REG_WINDOW_SIZE = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic       valid;
      origin_type origin;
      logic [8:0] distance;
   } cand_tag_type;

endpackage

// ===== rtl/delta_parent_selector_core.sv =====
// delta parent selector top level: frame store, candidate sequencer, scoring pipe
// depends on dps_pkg
//
// throughput: one item at a time, next item taken the cycle after the result is loaded;
// bit-serial remainder for the row column, then one frame store read per candidate
// reset clears control state and result registers; frame store contents undefined until written

module delta_parent_selector_core #(
   parameter int MAX_WINDOW    = dps_pkg::MAX_WINDOW_DEFAULT,
   parameter int MAX_POSITIONS = dps_pkg::MAX_POSITIONS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_mask_word0,
   input  logic [63:0] req_mask_word1,
   input  logic [63:0] req_mask_word2,
   input  logic [63:0] req_mask_word3,
   input  logic [8:0]  req_position,
   input  logic        req_has_previous_frame,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_chosen_cycles,
   output logic [8:0]  rsp_chosen_population,
   output logic [8:0]  rsp_add_count,
   output logic [8:0]  rsp_subtract_count,
   output logic [2:0]  rsp_origin,
   output logic [8:0]  rsp_distance,
   output logic        rsp_reference_is_zero,
   output logic [5:0]  rsp_local_cycles,
   output logic [5:0]  rsp_canonical_cycles,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int AW  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
   localparam int DW  = 9;
   localparam int SW  = DW + 8;
   localparam logic [6:0] WinMax = 7'(MAX_WINDOW);
   localparam int PosShift = 10 + AW;
   localparam logic [11:0] PosRecip = 12'((1 << PosShift) / MAX_POSITIONS);
   localparam logic [8:0] PosMod = 9'(MAX_POSITIONS);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MODR, ST_ISSUE, ST_DRAIN, ST_FINAL
   } state_type;

   state_type state_ff, state_in;

   logic [8:0]  row_width_ff;
   logic [6:0]  window_size_ff;
   logic [255:0] cur_ff;
   logic        hp_ff;
   logic [8:0]  p_ff;
   logic [8:0]  rem_ff;
   logic [DW-1:0] div_ff;
   logic [3:0]  k_ff;
   logic        left_ok_ff;
   dps_pkg::origin_type step_ff;
   logic [6:0]  d_ff;

   logic [255:0] mem [MAX_POSITIONS];
   logic [255:0] rd_data_ff;
   dps_pkg::cand_tag_type tag1_ff, tag2_ff, iss_tag;
   logic [AW-1:0] rd_addr;

   logic [5:0]  cnt_ff [8];
   logic [255:0] ref2_ff;

   logic [5:0]  best_cyc_ff;
   logic [8:0]  best_pop_ff;
   dps_pkg::origin_type best_origin_ff;
   logic [8:0]  best_dist_ff;
   logic [255:0] best_ref_ff;
   logic [5:0]  canon_ff;
   logic [5:0]  local_ff;

   logic        rsp_valid_ff;
   logic [5:0]  rsp_cyc_ff, rsp_local_ff, rsp_canon_ff;
   logic [8:0]  rsp_pop_ff, rsp_add_ff, rsp_sub_ff, rsp_dist_ff;
   logic [2:0]  rsp_origin_ff;
   logic        rsp_refzero_ff;

   logic        cfg_write;
   logic [8:0]  rw_eff;
   logic [6:0]  ws_eff;
   logic [6:0]  limit;
   logic [20:0] pos_prod;
   logic [8:0]  pos_q;
   logic [8:0]  pos_rem;
   logic [8:0]  pos_red;
   logic [SW-1:0] shifted;
   logic        ge;
   logic [8:0]  rem_next;
   logic        accept;
   logic        out_free;
   logic [255:0] rd_masked;
   logic [255:0] xor_v;
   logic [5:0]  worst;
   logic [8:0]  total;
   logic        better;
   logic [8:0]  addc, subc;

   // configuration port
   assign cfg_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      unique case (dps_pkg::reg_index_type'(paddr[2]))
         dps_pkg::REG_ROW_WIDTH:   prdata = {23'd0, row_width_ff};
         dps_pkg::REG_WINDOW_SIZE: prdata = {25'd0, window_size_ff};
         default:                  prdata = 32'd0;
      endcase
   end

   assign rw_eff = (row_width_ff == 9'd0) ? 9'd1 : row_width_ff;
   assign ws_eff = (window_size_ff > WinMax) ? WinMax : window_size_ff;
   assign limit  = ({2'd0, ws_eff} < p_ff) ? ws_eff : p_ff[6:0];

   // position wrap by reciprocal multiply, quotient low by at most one
   assign pos_prod = 21'(req_position) * 21'(PosRecip);
   assign pos_q    = 9'(pos_prod >> PosShift);
   assign pos_rem  = req_position - 9'(pos_q * PosMod);
   assign pos_red  = (int'(pos_rem) >= MAX_POSITIONS) ? (pos_rem - PosMod) : pos_rem;

   // restoring remainder step
   assign shifted  = SW'(div_ff) << k_ff;
   assign ge       = SW'(rem_ff) >= shifted;
   assign rem_next = ge ? (rem_ff - shifted[8:0]) : rem_ff;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // candidate issue
   always_comb begin
      iss_tag = '0;
      rd_addr = AW'(p_ff);
      if (state_ff == ST_ISSUE) begin
         iss_tag.origin = step_ff;
         case (step_ff)
            dps_pkg::ORIGIN_ZERO: begin
               iss_tag.valid = 1'b1;
            end
            dps_pkg::ORIGIN_LEFT: begin
               iss_tag.valid    = left_ok_ff;
               iss_tag.distance = 9'd1;
               rd_addr          = AW'(p_ff - 9'd1);
            end
            dps_pkg::ORIGIN_UP: begin
               iss_tag.valid    = (p_ff >= rw_eff);
               iss_tag.distance = rw_eff;
               rd_addr          = AW'(p_ff - rw_eff);
            end
            dps_pkg::ORIGIN_PREV: begin
               iss_tag.valid = hp_ff;
            end
            default: begin
               iss_tag.valid    = 1'b1;
               iss_tag.distance = {2'd0, d_ff};
               rd_addr          = AW'(p_ff - {2'd0, d_ff});
            end
         endcase
      end
   end

   // scoring
   assign rd_masked = (tag1_ff.origin == dps_pkg::ORIGIN_ZERO) ? '0 : rd_data_ff;
   assign xor_v     = cur_ff ^ rd_masked;

   always_comb begin
      worst = 6'd0;
      total = 9'd0;
      for (int b = 0; b < 8; b++) begin
         if (cnt_ff[b] > worst) begin
            worst = cnt_ff[b];
         end
         total = total + 9'(cnt_ff[b]);
      end
   end

   assign better = (worst < best_cyc_ff) || ((worst == best_cyc_ff) && (total < best_pop_ff));

   always_comb begin
      addc = 9'd0;
      subc = 9'd0;
      for (int i = 0; i < 256; i++) begin
         addc = addc + 9'(cur_ff[i] & ~best_ref_ff[i]);
         subc = subc + 9'(best_ref_ff[i] & ~cur_ff[i]);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_MODR;
         ST_MODR:  if (k_ff == 4'd0) state_in = ST_ISSUE;
         ST_ISSUE: begin
            if (step_ff == dps_pkg::ORIGIN_PREV && limit == 7'd0) begin
               state_in = ST_DRAIN;
            end else if (step_ff == dps_pkg::ORIGIN_WINDOW && d_ff == limit) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: if (!tag1_ff.valid && !tag2_ff.valid) state_in = ST_FINAL;
         ST_FINAL: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // frame store
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (state_ff == ST_FINAL && out_free) begin
         mem[AW'(p_ff)] <= cur_ff;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ref2_ff <= rd_masked;
      for (int b = 0; b < 8; b++) begin
         logic [5:0] c;
         c = 6'd0;
         for (int j = 0; j < 32; j++) begin
            c = c + 6'(xor_v[j * 8 + b]);
         end
         cnt_ff[b] <= c;
      end
      if (accept) begin
         cur_ff <= {req_mask_word3, req_mask_word2, req_mask_word1, req_mask_word0};
         hp_ff  <= req_has_previous_frame;
      end
      if (tag2_ff.valid && better) begin
         best_ref_ff <= ref2_ff;
      end
   end

   // control and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         row_width_ff   <= dps_pkg::ROW_WIDTH_RESET;
         window_size_ff <= dps_pkg::WINDOW_SIZE_RESET;
         tag1_ff        <= '0;
         tag2_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         p_ff           <= 9'd0;
         rem_ff         <= 9'd0;
         div_ff         <= '0;
         k_ff           <= 4'd0;
         left_ok_ff     <= 1'b0;
         step_ff        <= dps_pkg::ORIGIN_ZERO;
         d_ff           <= 7'd0;
         best_cyc_ff    <= 6'h3f;
         best_pop_ff    <= 9'h1ff;
         best_origin_ff <= dps_pkg::ORIGIN_ZERO;
         best_dist_ff   <= 9'd0;
         canon_ff       <= 6'd0;
         local_ff       <= 6'd0;
         rsp_cyc_ff     <= 6'd0;
         rsp_pop_ff     <= 9'd0;
         rsp_add_ff     <= 9'd0;
         rsp_sub_ff     <= 9'd0;
         rsp_origin_ff  <= 3'd0;
         rsp_dist_ff    <= 9'd0;
         rsp_refzero_ff <= 1'b0;
         rsp_local_ff   <= 6'd0;
         rsp_canon_ff   <= 6'd0;
      end else begin
         state_ff <= state_in;
         if (cfg_write) begin
            unique case (dps_pkg::reg_index_type'(paddr[2]))
               dps_pkg::REG_ROW_WIDTH:   row_width_ff   <= pwdata[8:0];
               dps_pkg::REG_WINDOW_SIZE: window_size_ff <= pwdata[6:0];
               default: ;
            endcase
         end
         if (state_ff == ST_FINAL && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         tag1_ff <= iss_tag;
         tag2_ff <= tag1_ff;

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  p_ff        <= pos_red;
                  rem_ff      <= pos_red;
                  div_ff      <= DW'(rw_eff);
                  k_ff        <= 4'd8;
                  step_ff     <= dps_pkg::ORIGIN_ZERO;
                  d_ff        <= 7'd1;
                  best_cyc_ff <= 6'h3f;
                  best_pop_ff <= 9'h1ff;
               end
            end
            ST_MODR: begin
               rem_ff <= rem_next;
               k_ff   <= k_ff - 4'd1;
               if (k_ff == 4'd0) begin
                  left_ok_ff <= (rem_next != 9'd0);
               end
            end
            ST_ISSUE: begin
               if (step_ff == dps_pkg::ORIGIN_WINDOW) begin
                  d_ff <= d_ff + 7'd1;
               end else begin
                  step_ff <= dps_pkg::origin_type'(step_ff + 3'd1);
               end
            end
            ST_FINAL: begin
               if (out_free) begin
                  rsp_cyc_ff     <= best_cyc_ff;
                  rsp_pop_ff     <= best_pop_ff;
                  rsp_add_ff     <= addc;
                  rsp_sub_ff     <= subc;
                  rsp_origin_ff  <= best_origin_ff;
                  rsp_dist_ff    <= best_dist_ff;
                  rsp_refzero_ff <= (best_ref_ff == '0);
                  rsp_local_ff   <= local_ff;
                  rsp_canon_ff   <= canon_ff;
               end
            end
            default: ;
         endcase

         // compare stage
         if (tag2_ff.valid) begin
            if (better) begin
               best_cyc_ff    <= worst;
               best_pop_ff    <= total;
               best_origin_ff <= tag2_ff.origin;
               best_dist_ff   <= tag2_ff.distance;
            end
            if (tag2_ff.origin != dps_pkg::ORIGIN_WINDOW) begin
               canon_ff <= better ? worst : best_cyc_ff;
            end
            if (tag2_ff.origin == dps_pkg::ORIGIN_ZERO) begin
               local_ff <= worst;
            end
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_chosen_cycles     = rsp_cyc_ff;
   assign rsp_chosen_population = rsp_pop_ff;
   assign rsp_add_count         = rsp_add_ff;
   assign rsp_subtract_count    = rsp_sub_ff;
   assign rsp_origin            = rsp_origin_ff;
   assign rsp_distance          = rsp_dist_ff;
   assign rsp_reference_is_zero = rsp_refzero_ff;
   assign rsp_local_cycles      = rsp_local_ff;
   assign rsp_canonical_cycles  = rsp_canon_ff;

endmodule

// ===== rtl/dps_checker.sv =====
// port-level checks on the delta parent selector results
// depends on dps_pkg; bound to delta_parent_selector_core

module dps_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [5:0] rsp_chosen_cycles,
   input logic [8:0] rsp_chosen_population,
   input logic [8:0] rsp_add_count,
   input logic [8:0] rsp_subtract_count,
   input logic [2:0] rsp_origin,
   input logic [8:0] rsp_distance,
   input logic       rsp_reference_is_zero,
   input logic [5:0] rsp_local_cycles,
   input logic [5:0] rsp_canonical_cycles
);

   a_zero_ref: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_origin == dps_pkg::ORIGIN_ZERO |->
         rsp_reference_is_zero && rsp_distance == 9'd0)
      else $error("zero origin with nonzero reference");

   a_pop_split: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_chosen_population == rsp_add_count + rsp_subtract_count)
      else $error("population differs from add plus subtract");

   a_cost_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_chosen_cycles <= rsp_canonical_cycles &&
         rsp_canonical_cycles <= rsp_local_cycles)
      else $error("chosen cost above a baseline cost");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_chosen_population))
      else $error("stalled item changed");

endmodule

bind delta_parent_selector_core dps_checker u_dps_checker (.*);

// ===== tb/delta_parent_selector_core_checker.sv =====
// parent selection checker: watches the item, result and register ports,
// predicts each result from its own copy of the frame store and compares
// depends on dps_pkg
`timescale 1ns / 100ps

module delta_parent_selector_core_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [63:0] req_mask_word0,
   input  logic [63:0] req_mask_word1,
   input  logic [63:0] req_mask_word2,
   input  logic [63:0] req_mask_word3,
   input  logic [8:0]  req_position,
   input  logic        req_has_previous_frame,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [5:0]  rsp_chosen_cycles,
   input  logic [8:0]  rsp_chosen_population,
   input  logic [8:0]  rsp_add_count,
   input  logic [8:0]  rsp_subtract_count,
   input  logic [2:0]  rsp_origin,
   input  logic [8:0]  rsp_distance,
   input  logic        rsp_reference_is_zero,
   input  logic [5:0]  rsp_local_cycles,
   input  logic [5:0]  rsp_canonical_cycles,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fails,
   output int          pending,
   output int          results_seen
);

   typedef struct {
      logic [5:0] chosen_cycles;
      logic [8:0] chosen_population;
      logic [8:0] add_count;
      logic [8:0] subtract_count;
      dps_pkg::origin_type origin;
      logic [8:0] distance;
      logic       reference_is_zero;
      logic [5:0] local_cycles;
      logic [5:0] canonical_cycles;
   } parent_pick_type;

   parent_pick_type expected_picks[$];
   logic [255:0] mask_store[dps_pkg::MAX_POSITIONS_DEFAULT];
   logic [8:0]   row_width;
   logic [6:0]   window_size;

   function automatic void bank_cost(input logic [255:0] x, output int worst, output int total);
      int bank[8];
      worst = 0;
      total = 0;
      for (int b = 0; b < 8; b++) bank[b] = 0;
      for (int i = 0; i < 256; i++) bank[i % 8] += x[i];
      for (int b = 0; b < 8; b++) begin
         total += bank[b];
         if (bank[b] > worst) worst = bank[b];
      end
   endfunction

   function automatic void offer(input logic [255:0] cur, input logic [255:0] cand,
                                 input dps_pkg::origin_type org, input int back_dist,
                                 inout int best_cyc, inout int best_pop,
                                 inout dps_pkg::origin_type best_org, inout int best_dist,
                                 inout logic [255:0] best_ref);
      int cyc, pop;
      bank_cost(cur ^ cand, cyc, pop);
      if (cyc < best_cyc || (cyc == best_cyc && pop < best_pop)) begin
         best_cyc  = cyc;
         best_pop  = pop;
         best_org  = org;
         best_dist = back_dist;
         best_ref  = cand;
      end
   endfunction

   function automatic parent_pick_type pick_parent(input logic [255:0] cur, input int p,
                                                   input bit prev);
      parent_pick_type r;
      int rw, ws, lim, cyc, pop, chosen_dist, canon;
      dps_pkg::origin_type org;
      logic [255:0] best_ref;
      rw = (row_width == 0) ? 1 : int'(row_width);
      ws = (window_size > dps_pkg::MAX_WINDOW_DEFAULT) ? dps_pkg::MAX_WINDOW_DEFAULT :
           int'(window_size);
      bank_cost(cur, cyc, pop);
      r.local_cycles = cyc[5:0];
      org = dps_pkg::ORIGIN_ZERO;
      chosen_dist = 0;
      best_ref = '0;
      if (p % rw != 0)
         offer(cur, mask_store[p - 1], dps_pkg::ORIGIN_LEFT, 1, cyc, pop, org, chosen_dist,
               best_ref);
      if (p >= rw)
         offer(cur, mask_store[p - rw], dps_pkg::ORIGIN_UP, rw, cyc, pop, org, chosen_dist,
               best_ref);
      if (prev)
         offer(cur, mask_store[p], dps_pkg::ORIGIN_PREV, 0, cyc, pop, org, chosen_dist,
               best_ref);
      canon = cyc;
      lim = (ws < p) ? ws : p;
      for (int d = 1; d <= lim; d++)
         offer(cur, mask_store[p - d], dps_pkg::ORIGIN_WINDOW, d, cyc, pop, org, chosen_dist,
               best_ref);
      r.chosen_cycles     = cyc[5:0];
      r.chosen_population = pop[8:0];
      r.add_count         = 9'($countones(cur & ~best_ref));
      r.subtract_count    = 9'($countones(best_ref & ~cur));
      r.origin            = org;
      r.distance          = chosen_dist[8:0];
      r.reference_is_zero = (best_ref == '0);
      r.canonical_cycles  = canon[5:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch in result %0d: %s got %0d expected %0d", results_seen, what, got,
               want);
      fails++;
   endtask

   initial begin
      fails = 0;
      pending = 0;
      results_seen = 0;
   end

   always @(posedge clock) begin
      logic [255:0] cur;
      int p;
      parent_pick_type want;
      if (reset) begin
         row_width <= dps_pkg::ROW_WIDTH_RESET;
         window_size <= dps_pkg::WINDOW_SIZE_RESET;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == dps_pkg::REG_ROW_WIDTH) row_width <= pwdata[8:0];
            else window_size <= pwdata[6:0];
         end
         if (req_valid && !req_stall) begin
            cur = {req_mask_word3, req_mask_word2, req_mask_word1, req_mask_word0};
            p = int'(req_position) % dps_pkg::MAX_POSITIONS_DEFAULT;
            expected_picks.push_back(pick_parent(cur, p, req_has_previous_frame));
            mask_store[p] = cur;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_picks.size() == 0) begin
               $display("unexpected result with nothing pending");
               fails++;
            end else begin
               want = expected_picks.pop_front();
               if (rsp_chosen_cycles != want.chosen_cycles)
                  report_mismatch("chosen_cycles", rsp_chosen_cycles, want.chosen_cycles);
               if (rsp_chosen_population != want.chosen_population)
                  report_mismatch("chosen_population", rsp_chosen_population,
                                  want.chosen_population);
               if (rsp_add_count != want.add_count)
                  report_mismatch("add_count", rsp_add_count, want.add_count);
               if (rsp_subtract_count != want.subtract_count)
                  report_mismatch("subtract_count", rsp_subtract_count, want.subtract_count);
               if (rsp_origin != want.origin)
                  report_mismatch("origin", rsp_origin, want.origin);
               if (rsp_distance != want.distance)
                  report_mismatch("distance", rsp_distance, want.distance);
               if (rsp_reference_is_zero != want.reference_is_zero)
                  report_mismatch("reference_is_zero", rsp_reference_is_zero,
                                  want.reference_is_zero);
               if (rsp_local_cycles != want.local_cycles)
                  report_mismatch("local_cycles", rsp_local_cycles, want.local_cycles);
               if (rsp_canonical_cycles != want.canonical_cycles)
                  report_mismatch("canonical_cycles", rsp_canonical_cycles,
                                  want.canonical_cycles);
            end
            results_seen++;
         end
         pending = expected_picks.size();
      end
   end

endmodule

// ===== tb/delta_parent_selector_core_tb.sv =====
// testbench top of the delta parent selector: clock, reset, item and register
// stimulus, receiver stalls, watchdog and verdict
// depends on dps_pkg, delta_parent_selector_core and its checker
`timescale 1ns / 100ps

module delta_parent_selector_core_tb;

   localparam int NPOS = dps_pkg::MAX_POSITIONS_DEFAULT;
   localparam int IDLE_LIMIT = 5000;
   localparam int SETTLE = 120;

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic [63:0] req_mask_word0, req_mask_word1, req_mask_word2, req_mask_word3;
   logic [8:0]  req_position;
   logic        req_has_previous_frame;
   logic        rsp_valid, rsp_stall;
   logic [5:0]  rsp_chosen_cycles, rsp_local_cycles, rsp_canonical_cycles;
   logic [8:0]  rsp_chosen_population, rsp_add_count, rsp_subtract_count, rsp_distance;
   logic [2:0]  rsp_origin;
   logic        rsp_reference_is_zero;
   logic        psel, penable, pwrite, pready;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;
   int          fails, pending, results_seen;

   bit           calm, hold_off;
   int           items_sent, idle_cycles;
   bit           written[NPOS];
   logic [255:0] sent_masks[NPOS];
   int           cur_row_width, cur_window, next_pos;

   delta_parent_selector_core dut (.*);

   delta_parent_selector_core_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // receiver side
   initial begin
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_stall = 1;
            repeat (400) @(negedge clock);
            hold_off = 0;
         end
         rsp_stall = calm ? 1'b0 : ($urandom_range(99) < 32);
      end
   end

   // watchdog on cycles with no accepted traffic
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
            idle_cycles = 0;
         else if (++idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL delta_parent_selector_core");
            $finish;
         end
      end
   end

   function automatic bit reads_written(input int p, input bit prev);
      int rw, ws, lim;
      rw = (cur_row_width == 0) ? 1 : cur_row_width;
      ws = (cur_window > dps_pkg::MAX_WINDOW_DEFAULT) ? dps_pkg::MAX_WINDOW_DEFAULT :
           cur_window;
      if (p % rw != 0 && !written[p - 1]) return 0;
      if (p >= rw && !written[p - rw]) return 0;
      if (prev && !written[p]) return 0;
      lim = (ws < p) ? ws : p;
      for (int d = 1; d <= lim; d++)
         if (!written[p - d]) return 0;
      return 1;
   endfunction

   function automatic logic [255:0] random_mask();
      return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
   endfunction

   task automatic send_item(input logic [255:0] m, input int p, input bit prev);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 32) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      {req_mask_word3, req_mask_word2, req_mask_word1, req_mask_word0} = m;
      req_position = p[8:0];
      req_has_previous_frame = prev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      written[p] = 1;
      sent_masks[p] = m;
      items_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      wait (pending == 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input dps_pkg::reg_index_type idx, input int value);
      @(negedge clock);
      psel = 1;
      penable = 0;
      pwrite = 1;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel = 0;
      penable = 0;
      if (idx == dps_pkg::REG_ROW_WIDTH) cur_row_width = value;
      else cur_window = value;
   endtask

   task automatic random_item();
      int p, k;
      bit prev;
      logic [255:0] m;
      p = -1;
      if ($urandom_range(99) < 30) begin
         repeat (20) begin
            k = $urandom_range(NPOS - 1);
            if (p < 0 && reads_written(k, 0)) p = k;
         end
      end
      if (p < 0) begin
         p = next_pos;
         next_pos = ($urandom_range(199) == 0) ? 0 : (next_pos + 1) % NPOS;
      end
      prev = written[p] && $urandom_range(1);
      if (prev && !reads_written(p, 1)) prev = 0;
      case ($urandom_range(9))
         0: m = '0;
         1: m = '1;
         2, 3: m = random_mask();
         default: begin
            k = $urandom_range(p < 70 ? p : 70);
            m = written[p - k] ? sent_masks[p - k] : random_mask();
            repeat ($urandom_range(4)) m[$urandom_range(255)] ^= 1'b1;
         end
      endcase
      send_item(m, p, prev);
   endtask

   initial begin
      logic [255:0] m;
      int rws[6], wss[6];
      calm = 0;
      hold_off = 0;
      items_sent = 0;
      next_pos = 0;
      cur_row_width = dps_pkg::ROW_WIDTH_RESET;
      cur_window = dps_pkg::WINDOW_SIZE_RESET;
      req_valid = 0;
      {req_mask_word3, req_mask_word2, req_mask_word1, req_mask_word0} = '0;
      req_position = 0;
      req_has_previous_frame = 0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = 0;
      pwdata = 0;
      reset = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: zero, all ones, bank patterns, left, up, previous frame, window picks
      for (int p = 0; p < 22; p++) begin
         case (p)
            0: m = '0;
            1: m = '1;
            2: m = {4{64'h0101010101010101}};
            3: m = {4{64'h8080808080808080}};
            4: m = {4{64'h00000000000000ff}};
            5, 6: m = sent_masks[p - 1] ^ 256'h1;
            20: m = sent_masks[0] ^ 256'h10;
            21: m = sent_masks[3];
            default: m = random_mask();
         endcase
         send_item(m, p, 0);
      end
      send_item('1, 1, 1);
      send_item(sent_masks[2] ^ 256'h4, 2, 1);
      next_pos = 22;

      rws = '{1, 511, 0, 7, 300, 13};
      wss = '{64, 1, 0, 127, 64, 5};
      for (int ph = 0; ph < 7; ph++) begin
         drain();
         if (ph < 6) begin
            write_reg(dps_pkg::REG_ROW_WIDTH, rws[ph]);
            write_reg(dps_pkg::REG_WINDOW_SIZE, wss[ph]);
         end else begin
            write_reg(dps_pkg::REG_ROW_WIDTH, $urandom_range(511));
            write_reg(dps_pkg::REG_WINDOW_SIZE, $urandom_range(127));
         end
         calm = (ph == 3);
         for (int i = 0; i < 190; i++) begin
            if (ph == 1 && i == 40) hold_off = 1;
            if (ph == 2 && i == 60) drain();
            random_item();
         end
      end
      calm = 0;
      @(negedge clock);
      req_valid = 0;
      wait (pending == 0);
      repeat (SETTLE) @(posedge clock);
      $display("sent %0d items over seven register settings, %0d results checked",
               items_sent, results_seen);
      $display("row widths 0 to 511 and windows 0 to 127 with stalls and a long hold-off");
      if (fails == 0) $display("PASS delta_parent_selector_core");
      else $display("FAIL delta_parent_selector_core");
      $finish;
   end

endmodule
